### design/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_BODY    = 3'd1,
      PH_ESC     = 3'd2,
      PH_HEX     = 3'd3,
      PH_PAIR_BS = 3'd4,
      PH_PAIR_U  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_NO_QUOTE   = 4'd1,
      ERR_UNTERM     = 4'd2,
      ERR_OPEN_ESC   = 4'd3,
      ERR_BAD_ESC    = 4'd4,
      ERR_SHORT_HEX  = 4'd5,
      ERR_BAD_HEX    = 4'd6,
      ERR_LONE_HIGH  = 4'd7,
      ERR_BAD_LOW    = 4'd8
   } err_type;

   localparam int MAX_DATA = 4;

   typedef struct packed {
      logic [2:0]                 data_cnt;
      logic [MAX_DATA-1:0][7:0]   data;
      logic                       has_tail;
      kind_type                   tail_kind;
      err_type                    tail_code;
   } job_type;

endpackage

### design/jsu_channels.sv
// Valid/ready channel interfaces for request bytes and decoded results.
interface jsu_req_if;
   import jsu_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       input_end;
   modport source (output valid, output in_byte, output input_end, input ready);
   modport sink   (input valid, input in_byte, input input_end, output ready);
endinterface

interface jsu_rsp_if;
   import jsu_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic [3:0] error_code;
   logic       last_of_run;
   modport source (output valid, output out_kind, output out_byte, output error_code,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input error_code,
                   input last_of_run, output ready);
endinterface

### design/jsu_front.sv
// Front end: parses one byte per transaction and builds a result job.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             input_end,
   output logic             push,
   output jsu_pkg::job_type job
);
   import jsu_pkg::*;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;

   phase_type   phase_ff, phase_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic [9:0]  high_saved_ff, high_saved_in;
   logic        second_half_ff, second_half_in;
   logic        hex_bad_ff, hex_bad_in;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      return r;
   endfunction

   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h22:   r = 9'h022;
         8'h5C:   r = 9'h05C;
         8'h2F:   r = 9'h02F;
         8'h62:   r = 9'h008;
         8'h66:   r = 9'h00C;
         8'h6E:   r = 9'h00A;
         8'h72:   r = 9'h00D;
         8'h74:   r = 9'h009;
         default: r = 9'h100;
      endcase
      return r;
   endfunction

   function automatic job_type utf8_job(input logic [20:0] cp);
      job_type j;
      j = '0;
      if (cp[20:7] == '0) begin
         j.data_cnt = 3'd1;
         j.data[0]  = cp[7:0];
      end else if (cp[20:11] == '0) begin
         j.data_cnt = 3'd2;
         j.data[0]  = {3'b110, cp[10:6]};
         j.data[1]  = {2'b10, cp[5:0]};
      end else if (cp[20:16] == '0) begin
         j.data_cnt = 3'd3;
         j.data[0]  = {4'b1110, cp[15:12]};
         j.data[1]  = {2'b10, cp[11:6]};
         j.data[2]  = {2'b10, cp[5:0]};
      end else begin
         j.data_cnt = 3'd4;
         j.data[0]  = {5'b11110, cp[20:18]};
         j.data[1]  = {2'b10, cp[17:12]};
         j.data[2]  = {2'b10, cp[11:6]};
         j.data[3]  = {2'b10, cp[5:0]};
      end
      return j;
   endfunction

   always_comb begin
      logic [4:0]  d;
      logic [15:0] v;
      logic        bad;
      logic        err;
      err_type     code;
      logic [8:0]  e;

      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      hex_value_in   = hex_value_ff;
      high_saved_in  = high_saved_ff;
      second_half_in = second_half_ff;
      hex_bad_in     = hex_bad_ff;
      job            = '0;
      err            = 1'b0;
      code           = ERR_NONE;
      d              = hex_digit(in_byte);
      bad            = hex_bad_ff | d[4];
      v              = {hex_value_ff[11:0], (d[4] ? 4'd0 : d[3:0])};
      e              = simple_escape(in_byte);

      case (phase_ff)
         PH_IDLE: begin
            if (in_byte == CH_QUOTE) begin
               phase_in = PH_BODY;
               if (input_end) begin
                  err = 1'b1;
                  code = ERR_UNTERM;
               end
            end else if (in_byte == 8'h20 || in_byte == 8'h09 ||
                         in_byte == 8'h0A || in_byte == 8'h0D) begin
               if (input_end) begin
                  err = 1'b1;
                  code = ERR_NO_QUOTE;
               end
            end else begin
               err = 1'b1;
               code = ERR_NO_QUOTE;
            end
         end
         PH_BODY: begin
            if (in_byte == CH_QUOTE) begin
               job.has_tail  = 1'b1;
               job.tail_kind = KIND_CLOSE;
               phase_in = PH_IDLE;
            end else if (in_byte == CH_BSL) begin
               if (input_end) begin
                  err = 1'b1;
                  code = ERR_OPEN_ESC;
               end else begin
                  phase_in = PH_ESC;
               end
            end else begin
               job.data_cnt = 3'd1;
               job.data[0]  = in_byte;
               if (input_end) begin
                  err = 1'b1;
                  code = ERR_UNTERM;
               end
            end
         end
         PH_ESC: begin
            if (in_byte == CH_U) begin
               if (input_end) begin
                  err = 1'b1;
                  code = ERR_SHORT_HEX;
               end else begin
                  phase_in       = PH_HEX;
                  digit_count_in = 2'd0;
                  hex_value_in   = '0;
                  hex_bad_in     = 1'b0;
                  second_half_in = 1'b0;
               end
            end else if (e[8]) begin
               err = 1'b1;
               code = ERR_BAD_ESC;
            end else begin
               phase_in     = PH_BODY;
               job.data_cnt = 3'd1;
               job.data[0]  = e[7:0];
               if (input_end) begin
                  err = 1'b1;
                  code = ERR_UNTERM;
               end
            end
         end
         PH_HEX: begin
            hex_bad_in   = bad;
            hex_value_in = v;
            if (digit_count_ff != 2'd3) begin
               if (input_end) begin
                  err = 1'b1;
                  code = ERR_SHORT_HEX;
               end else begin
                  digit_count_in = digit_count_ff + 2'd1;
               end
            end else begin
               digit_count_in = 2'd0;
               if (bad) begin
                  err = 1'b1;
                  code = ERR_BAD_HEX;
               end else if (second_half_ff) begin
                  if (v[15:10] != 6'b110111) begin
                     err = 1'b1;
                     code = ERR_BAD_LOW;
                  end else begin
                     job = utf8_job(21'h10000 + {1'b0, high_saved_ff, v[9:0]});
                     second_half_in = 1'b0;
                     high_saved_in  = '0;
                     hex_value_in   = '0;
                     phase_in       = PH_BODY;
                     if (input_end) begin
                        err = 1'b1;
                        code = ERR_UNTERM;
                     end
                  end
               end else if (v[15:10] == 6'b110110) begin
                  if (input_end) begin
                     err = 1'b1;
                     code = ERR_LONE_HIGH;
                  end else begin
                     high_saved_in = v[9:0];
                     hex_value_in  = '0;
                     phase_in      = PH_PAIR_BS;
                  end
               end else begin
                  job = utf8_job({5'd0, v});
                  hex_value_in = '0;
                  phase_in     = PH_BODY;
                  if (input_end) begin
                     err = 1'b1;
                     code = ERR_UNTERM;
                  end
               end
            end
         end
         PH_PAIR_BS: begin
            if (in_byte != CH_BSL || input_end) begin
               err = 1'b1;
               code = ERR_LONE_HIGH;
            end else begin
               phase_in = PH_PAIR_U;
            end
         end
         PH_PAIR_U: begin
            if (in_byte != CH_U) begin
               err = 1'b1;
               code = ERR_LONE_HIGH;
            end else if (input_end) begin
               err = 1'b1;
               code = ERR_SHORT_HEX;
            end else begin
               phase_in       = PH_HEX;
               digit_count_in = 2'd0;
               hex_value_in   = '0;
               hex_bad_in     = 1'b0;
               second_half_in = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (err) begin
         job.has_tail   = 1'b1;
         job.tail_kind  = KIND_ERROR;
         job.tail_code  = code;
      end
      if (err || phase_in == PH_IDLE) begin
         phase_in       = PH_IDLE;
         digit_count_in = '0;
         hex_value_in   = '0;
         high_saved_in  = '0;
         second_half_in = 1'b0;
         hex_bad_in     = 1'b0;
      end
      push = accept && (job.has_tail || job.data_cnt != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         digit_count_ff <= '0;
         hex_value_ff   <= '0;
         high_saved_ff  <= '0;
         second_half_ff <= 1'b0;
         hex_bad_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         hex_value_ff   <= hex_value_in;
         high_saved_ff  <= high_saved_in;
         second_half_ff <= second_half_in;
         hex_bad_ff     <= hex_bad_in;
      end
   end

endmodule

### design/jsu_queue.sv
// Two-entry job queue between the parser and the result serializer.
module jsu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output jsu_pkg::job_type head
);
   import jsu_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

### design/jsu_back.sv
// Back end: emits the results of the head job one per transaction.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  jsu_pkg::job_type job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       out_kind,
   output logic [7:0]       out_byte,
   output logic [3:0]       error_code,
   output logic             last_of_run
);
   import jsu_pkg::*;

   logic [2:0] sub_ff, sub_in;
   logic [2:0] total;
   logic       fire;

   assign total     = job.data_cnt + {2'd0, job.has_tail};
   assign rsp_valid = job_valid;
   assign fire      = rsp_valid && rsp_ready;
   assign last_of_run = (sub_ff == total - 3'd1);
   assign pop       = fire && last_of_run;

   always_comb begin
      if (sub_ff < job.data_cnt) begin
         out_kind   = KIND_DATA;
         out_byte   = job.data[sub_ff[1:0]];
         error_code = ERR_NONE;
      end else begin
         out_kind   = job.tail_kind;
         out_byte   = 8'd0;
         error_code = job.tail_code;
      end
      sub_in = sub_ff;
      if (fire) sub_in = last_of_run ? 3'd0 : sub_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) sub_ff <= '0;
      else sub_ff <= sub_in;
   end

endmodule

### design/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
//   channel  dir  payload                                       handshake
//   req_ch   in   in_byte[8], input_end                         valid/ready
//   rsp_ch   out  out_kind[2], out_byte[8], error_code[4], last valid/ready
//
// One input byte is taken per cycle while the two-entry job queue has room.
// Each byte yields zero to five results; the serializer drains one result per
// cycle while rsp_ch is ready, and a job leaves the queue with its last result.
// Reset is synchronous: parser returns to idle, queue and serializer empty.
// A stalled rsp_ch holds its result; req_ch stalls only when the queue is full.
module json_string_unescape_utf8 (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);
   import jsu_pkg::*;

   logic    accept;
   logic    push;
   job_type push_job;
   logic    full;
   logic    pop;
   logic    not_empty;
   job_type head;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_ch.in_byte),
      .input_end (req_ch.input_end),
      .push      (push),
      .job       (push_job)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (not_empty),
      .job         (head),
      .pop         (pop),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .out_kind    (rsp_ch.out_kind),
      .out_byte    (rsp_ch.out_byte),
      .error_code  (rsp_ch.error_code),
      .last_of_run (rsp_ch.last_of_run)
   );

endmodule

### tb/sv/json_string_unescape_utf8_check.sv
// Predicts the decoded JSON string output and checks every result transaction.
module json_string_unescape_utf8_check (
   input  logic clock,
   input  logic reset,
   jsu_req_if   req_ch,
   jsu_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending
);
   import jsu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0]  CH_QUOTE  = 8'h22;
   localparam logic [7:0]  CH_BSLASH = 8'h5C;
   localparam logic [7:0]  CH_U      = 8'h75;
   localparam logic [15:0] HIGH_MIN  = 16'hD800;
   localparam logic [15:0] HIGH_MAX  = 16'hDBFF;
   localparam logic [15:0] LOW_MIN   = 16'hDC00;
   localparam logic [15:0] LOW_MAX   = 16'hDFFF;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      err_type    code;
      logic       last;
   } decoded_type;

   decoded_type decoded_q[$];
   int          failures;

   phase_type   ph;
   logic [1:0]  digits;
   logic [15:0] hex_acc;
   logic [9:0]  high_half;
   logic        low_pending;
   logic        hex_junk;

   function automatic void go_idle();
      ph          = PH_IDLE;
      digits      = '0;
      hex_acc     = '0;
      high_half   = '0;
      low_pending = 1'b0;
      hex_junk    = 1'b0;
   endfunction

   function automatic void emit(kind_type k, logic [7:0] b, err_type c);
      decoded_type item;
      item.kind      = k;
      item.data_byte = b;
      item.code      = c;
      item.last      = 1'b0;
      decoded_q.insert(decoded_q.size(), item);
   endfunction

   function automatic void fail_with(err_type c);
      emit(KIND_ERROR, 8'h00, c);
      go_idle();
   endfunction

   function automatic void end_check(logic e);
      if (e) fail_with(ERR_UNTERM);
   endfunction

   function automatic void emit_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
         emit(KIND_DATA, cp[7:0], ERR_NONE);
      end else if (cp < 21'h800) begin
         emit(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end else if (cp < 21'h10000) begin
         emit(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end else begin
         emit(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
         emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end
   endfunction

   // 16 marks a byte that is not a hex digit
   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
      return 5'd16;
   endfunction

   function automatic logic [8:0] escape_char(logic [7:0] c);
      case (c)
         8'h22:   return 9'h022;
         8'h5C:   return 9'h05C;
         8'h2F:   return 9'h02F;
         8'h62:   return 9'h008;
         8'h66:   return 9'h00C;
         8'h6E:   return 9'h00A;
         8'h72:   return 9'h00D;
         8'h74:   return 9'h009;
         default: return 9'h100;
      endcase
   endfunction

   function automatic void hex_digit_step(logic [7:0] c, logic e);
      logic [4:0]  d;
      logic [15:0] v;
      logic [20:0] cp;
      d = hex_nibble(c);
      if (d[4]) begin
         hex_junk = 1'b1;
         d = '0;
      end
      hex_acc = {hex_acc[11:0], d[3:0]};
      if (digits < 2'd3) begin
         if (e) begin
            fail_with(ERR_SHORT_HEX);
            return;
         end
         digits = digits + 2'd1;
         return;
      end
      digits = '0;
      if (hex_junk) begin
         fail_with(ERR_BAD_HEX);
         return;
      end
      v = hex_acc;
      if (low_pending) begin
         if (v < LOW_MIN || v > LOW_MAX) begin
            fail_with(ERR_BAD_LOW);
            return;
         end
         cp = 21'h10000 + {1'b0, high_half, 10'd0} + 21'(v - LOW_MIN);
         low_pending = 1'b0;
         high_half   = '0;
         hex_acc     = '0;
         ph          = PH_BODY;
         emit_utf8(cp);
         end_check(e);
         return;
      end
      if (v >= HIGH_MIN && v <= HIGH_MAX) begin
         if (e) begin
            fail_with(ERR_LONE_HIGH);
            return;
         end
         high_half = 10'(v - HIGH_MIN);
         hex_acc   = '0;
         ph        = PH_PAIR_BS;
         return;
      end
      hex_acc = '0;
      ph      = PH_BODY;
      emit_utf8({5'd0, v});
      end_check(e);
   endfunction

   function automatic void unescape_byte(logic [7:0] c, logic e);
      int         mark;
      logic [8:0] esc;
      mark = decoded_q.size();
      case (ph)
         PH_IDLE: begin
            if (c == CH_QUOTE) begin
               ph = PH_BODY;
               end_check(e);
            end else if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
               if (e) fail_with(ERR_NO_QUOTE);
            end else begin
               fail_with(ERR_NO_QUOTE);
            end
         end
         PH_BODY: begin
            if (c == CH_QUOTE) begin
               emit(KIND_CLOSE, 8'h00, ERR_NONE);
               go_idle();
            end else if (c == CH_BSLASH) begin
               if (e) fail_with(ERR_OPEN_ESC);
               else ph = PH_ESC;
            end else begin
               emit(KIND_DATA, c, ERR_NONE);
               end_check(e);
            end
         end
         PH_ESC: begin
            if (c == CH_U) begin
               if (e) begin
                  fail_with(ERR_SHORT_HEX);
               end else begin
                  ph          = PH_HEX;
                  digits      = '0;
                  hex_acc     = '0;
                  hex_junk    = 1'b0;
                  low_pending = 1'b0;
               end
            end else begin
               esc = escape_char(c);
               if (esc[8]) begin
                  fail_with(ERR_BAD_ESC);
               end else begin
                  ph = PH_BODY;
                  emit(KIND_DATA, esc[7:0], ERR_NONE);
                  end_check(e);
               end
            end
         end
         PH_HEX: hex_digit_step(c, e);
         PH_PAIR_BS: begin
            if (c != CH_BSLASH || e) fail_with(ERR_LONE_HIGH);
            else ph = PH_PAIR_U;
         end
         PH_PAIR_U: begin
            if (c != CH_U) begin
               fail_with(ERR_LONE_HIGH);
            end else if (e) begin
               fail_with(ERR_SHORT_HEX);
            end else begin
               ph          = PH_HEX;
               digits      = '0;
               hex_acc     = '0;
               hex_junk    = 1'b0;
               low_pending = 1'b1;
            end
         end
         default: go_idle();
      endcase
      if (decoded_q.size() > mark) decoded_q[decoded_q.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_result();
      decoded_type want;
      if (decoded_q.size() == 0) begin
         $error("unexpected result: out_kind %0d out_byte %h error_code %0d last_of_run %b",
                rsp_ch.out_kind, rsp_ch.out_byte, rsp_ch.error_code, rsp_ch.last_of_run);
         failures++;
         return;
      end
      want = decoded_q.pop_front();
      if (rsp_ch.out_kind !== want.kind) begin
         $error("out_kind expected %0d got %0d", want.kind, rsp_ch.out_kind);
         failures++;
      end
      if (rsp_ch.out_byte !== want.data_byte) begin
         $error("out_byte expected %h got %h", want.data_byte, rsp_ch.out_byte);
         failures++;
      end
      if (rsp_ch.error_code !== want.code) begin
         $error("error_code expected %0d got %0d", want.code, rsp_ch.error_code);
         failures++;
      end
      if (rsp_ch.last_of_run !== want.last) begin
         $error("last_of_run expected %b got %b", want.last, rsp_ch.last_of_run);
         failures++;
      end
   endfunction

   initial begin
      failures   = 0;
      fail_count = 0;
      pending    = 0;
      go_idle();
   end

   always @(posedge clock) begin
      if (reset) begin
         go_idle();
         decoded_q.delete();
      end else begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            unescape_byte(req_ch.in_byte, req_ch.input_end);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            compare_result();
      end
      pending    <= decoded_q.size();
      fail_count <= failures;
   end

endmodule

### tb/sv/tb_json_string_unescape_utf8.sv
// Stimulus, clocking and verdict for the JSON string unescaper.
module tb_json_string_unescape_utf8;
   import jsu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam int         RANDOM_BYTES = 180;
   localparam int         QUIET_LIMIT  = 3000;

   logic clock;
   logic reset;

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   int         fail_count;
   int         pending;
   int         sent;
   int         quiet;
   int         ready_hold;
   logic [8:0] text_q[$];

   json_string_unescape_utf8 DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   json_string_unescape_utf8_check decode_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // hold rsp ready high or low for a random stretch
   initial ready_hold = 0;
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 99) < 65) begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= $urandom_range(1, 40);
      end else begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= idle_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic void push_char(logic [7:0] c, logic e);
      text_q.insert(text_q.size(), {e, c});
   endfunction

   function automatic void push_str(string s, logic end_last);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], end_last && (i == s.len() - 1));
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0:       return 8'h20;
         1:       return 8'h09;
         2:       return 8'h0A;
         default: return 8'h0D;
      endcase
   endfunction

   function automatic void push_uescape(logic [15:0] v);
      push_char(CH_BSLASH, 1'b0);
      push_char(CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) begin
         if ($urandom_range(0, 99) < 4) push_char(8'h67 + 8'($urandom_range(0, 19)), 1'b0);
         else push_char(hex_char(v[i*4 +: 4]), 1'b0);
      end
   endfunction

   function automatic void build_string();
      string      esc_letters;
      int         start;
      int         cut;
      int         n_elem;
      int         r;
      logic [15:0] v;
      esc_letters = "\"\\/bfnrt";
      start = text_q.size();
      repeat ($urandom_range(0, 2)) push_char(blank_char(), 1'b0);
      push_char(CH_QUOTE, 1'b0);
      n_elem = $urandom_range(0, 6);
      repeat (n_elem) begin
         r = $urandom_range(0, 9);
         if (r < 4) begin
            push_char(plain_byte(), 1'b0);
         end else if (r < 6) begin
            push_char(CH_BSLASH, 1'b0);
            push_char(esc_letters[$urandom_range(0, 7)], 1'b0);
         end else if (r < 9) begin
            case ($urandom_range(0, 4))
               0:       v = 16'($urandom_range(0, 16'h7F));
               1:       v = 16'($urandom_range(16'h80, 16'h7FF));
               2:       v = 16'($urandom_range(16'h800, 16'hFFFF));
               3:       v = 16'($urandom_range(16'hDC00, 16'hDFFF));
               default: v = 16'($urandom);
            endcase
            push_uescape(v);
         end else begin
            push_uescape(16'($urandom_range(16'hD800, 16'hDBFF)));
            r = $urandom_range(0, 9);
            if (r < 8) push_uescape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            else if (r == 8) push_uescape(16'($urandom));
            else push_char(plain_byte(), 1'b0);
         end
      end
      push_char(CH_QUOTE, 1'b0);
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(start, text_q.size() - 1);
         text_q[cut][8] = 1'b1;
         while (text_q.size() > cut + 1) void'(text_q.pop_back());
      end else if ($urandom_range(0, 9) == 0) begin
         text_q[text_q.size() - 1][8] = 1'b1;
      end
   endfunction

   function automatic void build_noise();
      case ($urandom_range(0, 3))
         0: ;
         1: push_str("\"\\", 1'b0);
         2: push_str("\"\\u", 1'b0);
         default: begin
            push_char(CH_QUOTE, 1'b0);
            push_uescape(16'($urandom_range(16'hD800, 16'hDBFF)));
         end
      endcase
      repeat ($urandom_range(1, 6))
         push_char(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic e, input int gap);
      logic rdy;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.in_byte   <= b;
      req_ch.input_end <= e;
      do begin
         @(negedge clock);
         rdy = req_ch.ready;
         @(posedge clock);
      end while (rdy !== 1'b1);
   endtask

   task automatic send_text(input bit no_gaps);
      foreach (text_q[i]) begin
         put_byte(text_q[i][7:0], text_q[i][8], no_gaps ? 0 : idle_len());
         sent++;
      end
      text_q.delete();
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.in_byte   = 8'h00;
      req_ch.input_end = 1'b0;
      rsp_ch.ready     = 1'b0;
      sent             = 0;
      quiet            = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      push_str("x", 1'b0);
      push_str(" ", 1'b1);
      push_char(8'h09, 1'b0);
      push_char(8'h0A, 1'b0);
      push_char(8'h0D, 1'b0);
      push_str("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
      push_str("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\"", 1'b0);
      push_str("\"\\uD83D\\uDE00\\ud800\\udc00\\uDBFF\\uDFFF\\uDC00\"", 1'b0);
      push_char(CH_QUOTE, 1'b0);
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b0);
      push_char(8'h7F, 1'b0);
      push_char(8'h80, 1'b0);
      push_char(8'h61, 1'b1);
      push_str("\"", 1'b1);
      push_str("\"\\", 1'b1);
      push_str("\"\\q", 1'b0);
      push_str("\"\\u", 1'b1);
      push_str("\"\\u12", 1'b1);
      push_str("\"\\uxy1", 1'b1);
      push_str("\"\\uzz12", 1'b0);
      push_str("\"\\uD800x", 1'b0);
      push_str("\"\\uD800\\x", 1'b0);
      push_str("\"\\uD800", 1'b1);
      push_str("\"\\uD800\\", 1'b1);
      push_str("\"\\uD800\\u0041", 1'b0);
      push_str("\"\\uD800\\u", 1'b1);
      push_str("\"\\uDBFF\\uDFFF", 1'b1);
      push_str("\"\\n", 1'b1);
      push_str("\"\\u0041", 1'b1);
      push_str(" \"ok\"", 1'b1);
      send_text(1'b0);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 3) == 0) build_noise();
         else build_string();
         send_text($urandom_range(0, 3) == 0);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
